// ----- src/scr_pkg.sv -----
`timescale 1ns / 1ps
// Shared widths, types, register indexes and helpers for the segment contact resolver.
// Depends on nothing; every other file of the block imports it.
package scr_pkg;

    // Fixed point format of coordinates.
    localparam int COORD_W   = 32;
    localparam int FRAC_W    = 16;

    // Widths of the intermediate values.
    localparam int DIFF_W    = COORD_W + 1;          // difference of two coordinates
    localparam int MAG_W     = COORD_W;              // magnitude of such a difference
    localparam int PROD_W    = 2 * MAG_W;            // product of two magnitudes
    localparam int LEN_W     = PROD_W + 1;           // sum of two products
    localparam int DOT_W     = LEN_W + 1;            // signed sum of two products
    localparam int DOT_LO_W  = MAG_W + 1;            // low slice of the dot product
    localparam int DOT_HI_W  = LEN_W - DOT_LO_W;     // high slice of the dot product
    localparam int NUM_W     = MAG_W + LEN_W;        // dividend of the projection
    localparam int Q_W       = COORD_W + 1;          // projection quotient
    localparam int DIV_STEPS = Q_W;                  // one quotient bit per stage
    localparam int DIV_LAT   = DIV_STEPS + 1;        // plus the rounding stage
    localparam int ERR_W     = COORD_W + 2;          // displacement before saturation
    localparam int WIDE_W    = ERR_W + 1;            // position minus displacement
    localparam int SQ_MAG_W  = ERR_W - 1;
    localparam int SQ_W      = 2 * SQ_MAG_W;
    localparam int DSQ_W     = SQ_W + 1;
    localparam int THR_W     = 32;
    localparam int CFG_IDX_W = 3;

    typedef logic [COORD_W-1:0]  coord_t;
    typedef logic [DIFF_W-1:0]   diff_t;
    typedef logic [MAG_W-1:0]    mag_t;
    typedef logic [PROD_W-1:0]   prod_t;
    typedef logic [LEN_W-1:0]    len_t;
    typedef logic [DOT_W-1:0]    dot_t;
    typedef logic [NUM_W-1:0]    num_t;
    typedef logic [Q_W-1:0]      quot_t;
    typedef logic [ERR_W-1:0]    err_t;
    typedef logic [THR_W-1:0]    thr_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_X = 3'd0,
        CFG_START_Y = 3'd1,
        CFG_END_X   = 3'd2,
        CFG_END_Y   = 3'd3,
        CFG_DIST_SQ = 3'd4
    } cfg_idx_t;

    // Threshold after reset is one half.
    localparam thr_t DIST_SQ_RESET = thr_t'(1) << (FRAC_W - 1);

    // Per-item control and pass-through data that travels beside the dividers.
    typedef struct packed {
        logic   valid;
        logic   proj;       // nearest point lies inside the segment
        logic   sgn_x;      // segment direction x is negative
        logic   sgn_y;
        diff_t  rx;         // position minus start point
        diff_t  ry;
        err_t   ex_alt;     // displacement when the projection is not used
        err_t   ey_alt;
        coord_t px;
        coord_t py;
        coord_t vx;
        coord_t vy;
    } side_t;

    // One result item.
    typedef struct packed {
        coord_t disp_x;
        coord_t disp_y;
        logic   contact;
        coord_t new_pos_x;
        coord_t new_pos_y;
        coord_t new_vel_x;
        coord_t new_vel_y;
    } res_t;

    // Magnitude of a coordinate difference; it always fits MAG_W bits.
    function automatic mag_t abs_diff(input diff_t v);
        diff_t n;
        n = v[DIFF_W-1] ? -v : v;
        return n[MAG_W-1:0];
    endfunction

    // Magnitude of a displacement.
    function automatic logic [SQ_MAG_W-1:0] abs_err(input err_t v);
        err_t n;
        n = v[ERR_W-1] ? -v : v;
        return n[SQ_MAG_W-1:0];
    endfunction

    // Clamp a wide signed value to the coordinate range.
    function automatic coord_t sat_wide(input logic [WIDE_W-1:0] v);
        logic [WIDE_W-COORD_W:0] top;
        top = v[WIDE_W-1:COORD_W-1];
        if ((&top) || !(|top)) begin
            return v[COORD_W-1:0];
        end
        else if (v[WIDE_W-1]) begin
            return {1'b1, {(COORD_W-1){1'b0}}};
        end
        else begin
            return {1'b0, {(COORD_W-1){1'b1}}};
        end
    endfunction

endpackage

// ----- src/scr_front.sv -----
`timescale 1ns / 1ps
// Front stages: offsets, dot product, segment length, case selection and the
// projection dividends. Depends on scr_pkg.
module scr_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  scr_pkg::coord_t pos_x,
    input  scr_pkg::coord_t pos_y,
    input  scr_pkg::coord_t vel_x,
    input  scr_pkg::coord_t vel_y,
    input  scr_pkg::coord_t seg_start_x,
    input  scr_pkg::coord_t seg_start_y,
    input  scr_pkg::coord_t seg_end_x,
    input  scr_pkg::coord_t seg_end_y,
    output scr_pkg::side_t  side,
    output scr_pkg::num_t   num_x,
    output scr_pkg::num_t   num_y,
    output scr_pkg::len_t   len
);
    import scr_pkg::*;

    // Carried item data of each stage, valid bit included.
    side_t s0_reg, s1_reg, s2_reg, s3_reg, s4_reg, s5_reg;

    // Stage 0: differences.
    diff_t dx0_reg, dy0_reg;
    // Stage 1: products of magnitudes.
    mag_t  mdx1_reg, mdy1_reg;
    prod_t prx1_reg, pry1_reg, lxx1_reg, lyy1_reg;
    logic  negx1_reg, negy1_reg, zero1_reg;
    // Stage 2: dot product and squared length.
    mag_t  mdx2_reg, mdy2_reg;
    dot_t  dot2_reg;
    len_t  len2_reg;
    logic  zero2_reg;
    // Stage 3: case selection.
    mag_t  mdx3_reg, mdy3_reg;
    len_t  dotm3_reg, len3_reg;
    // Stage 4: partial products of the dividends.
    logic [MAG_W+DOT_LO_W-1:0] plox4_reg, ploy4_reg;
    logic [MAG_W+DOT_HI_W-1:0] phix4_reg, phiy4_reg;
    len_t  len4_reg;
    // Stage 5: dividends.
    num_t  numx5_reg, numy5_reg;
    len_t  len5_reg;

    // Stage 0: offsets from the start point and the segment direction.
    diff_t dx_c, dy_c;
    assign dx_c = {seg_end_x[COORD_W-1], seg_end_x} - {seg_start_x[COORD_W-1], seg_start_x};
    assign dy_c = {seg_end_y[COORD_W-1], seg_end_y} - {seg_start_y[COORD_W-1], seg_start_y};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_reg  <= '0;
            dx0_reg <= '0;
            dy0_reg <= '0;
        end
        else if (en)
        begin
            s0_reg.valid  <= in_valid;
            s0_reg.proj   <= 1'b0;
            s0_reg.sgn_x  <= dx_c[DIFF_W-1];
            s0_reg.sgn_y  <= dy_c[DIFF_W-1];
            s0_reg.rx     <= {pos_x[COORD_W-1], pos_x} - {seg_start_x[COORD_W-1], seg_start_x};
            s0_reg.ry     <= {pos_y[COORD_W-1], pos_y} - {seg_start_y[COORD_W-1], seg_start_y};
            s0_reg.ex_alt <= '0;
            s0_reg.ey_alt <= '0;
            s0_reg.px     <= pos_x;
            s0_reg.py     <= pos_y;
            s0_reg.vx     <= vel_x;
            s0_reg.vy     <= vel_y;
            dx0_reg       <= dx_c;
            dy0_reg       <= dy_c;
        end
    end

    // Stage 1: magnitude products for the dot product and the length.
    mag_t mrx_c, mry_c, mdx_c, mdy_c;
    assign mrx_c = abs_diff(s0_reg.rx);
    assign mry_c = abs_diff(s0_reg.ry);
    assign mdx_c = abs_diff(dx0_reg);
    assign mdy_c = abs_diff(dy0_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg    <= '0;
            mdx1_reg  <= '0;
            mdy1_reg  <= '0;
            prx1_reg  <= '0;
            pry1_reg  <= '0;
            lxx1_reg  <= '0;
            lyy1_reg  <= '0;
            negx1_reg <= 1'b0;
            negy1_reg <= 1'b0;
            zero1_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_reg    <= s0_reg;
            mdx1_reg  <= mdx_c;
            mdy1_reg  <= mdy_c;
            prx1_reg  <= mrx_c * mdx_c;
            pry1_reg  <= mry_c * mdy_c;
            lxx1_reg  <= mdx_c * mdx_c;
            lyy1_reg  <= mdy_c * mdy_c;
            negx1_reg <= s0_reg.rx[DIFF_W-1] ^ dx0_reg[DIFF_W-1];
            negy1_reg <= s0_reg.ry[DIFF_W-1] ^ dy0_reg[DIFF_W-1];
            zero1_reg <= (dx0_reg == '0) && (dy0_reg == '0);
        end
    end

    // Stage 2: signed dot product and squared length.
    dot_t tx_c, ty_c;
    assign tx_c = negx1_reg ? -dot_t'(prx1_reg) : dot_t'(prx1_reg);
    assign ty_c = negy1_reg ? -dot_t'(pry1_reg) : dot_t'(pry1_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_reg    <= '0;
            mdx2_reg  <= '0;
            mdy2_reg  <= '0;
            dot2_reg  <= '0;
            len2_reg  <= '0;
            zero2_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_reg    <= s1_reg;
            mdx2_reg  <= mdx1_reg;
            mdy2_reg  <= mdy1_reg;
            dot2_reg  <= tx_c + ty_c;
            len2_reg  <= len_t'(lxx1_reg) + len_t'(lyy1_reg);
            zero2_reg <= zero1_reg;
        end
    end

    // Stage 3: pick start point, end point or projection.
    logic dot_neg_c, dot_gt_c, to_start_c;
    err_t end_ex_c, end_ey_c;
    side_t s3_next;
    assign dot_neg_c  = dot2_reg[DOT_W-1];
    assign dot_gt_c   = !dot_neg_c && (dot2_reg[LEN_W-1:0] > len2_reg);
    assign to_start_c = zero2_reg || dot_neg_c;
    assign end_ex_c   = {{2{s2_reg.px[COORD_W-1]}}, s2_reg.px}
                      - {{2{seg_end_x[COORD_W-1]}}, seg_end_x};
    assign end_ey_c   = {{2{s2_reg.py[COORD_W-1]}}, s2_reg.py}
                      - {{2{seg_end_y[COORD_W-1]}}, seg_end_y};

    always_comb
    begin
        s3_next        = s2_reg;
        s3_next.proj   = !to_start_c && !dot_gt_c;
        s3_next.ex_alt = to_start_c ? {s2_reg.rx[DIFF_W-1], s2_reg.rx} : end_ex_c;
        s3_next.ey_alt = to_start_c ? {s2_reg.ry[DIFF_W-1], s2_reg.ry} : end_ey_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_reg    <= '0;
            mdx3_reg  <= '0;
            mdy3_reg  <= '0;
            dotm3_reg <= '0;
            len3_reg  <= '0;
        end
        else if (en)
        begin
            s3_reg    <= s3_next;
            mdx3_reg  <= mdx2_reg;
            mdy3_reg  <= mdy2_reg;
            dotm3_reg <= dot2_reg[LEN_W-1:0];
            len3_reg  <= len2_reg;
        end
    end

    // Stage 4: partial products of direction times dot product.
    logic [DOT_LO_W-1:0] dlo_c;
    logic [DOT_HI_W-1:0] dhi_c;
    assign dlo_c = dotm3_reg[DOT_LO_W-1:0];
    assign dhi_c = dotm3_reg[LEN_W-1:DOT_LO_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_reg    <= '0;
            plox4_reg <= '0;
            ploy4_reg <= '0;
            phix4_reg <= '0;
            phiy4_reg <= '0;
            len4_reg  <= '0;
        end
        else if (en)
        begin
            s4_reg    <= s3_reg;
            plox4_reg <= mdx3_reg * dlo_c;
            ploy4_reg <= mdy3_reg * dlo_c;
            phix4_reg <= mdx3_reg * dhi_c;
            phiy4_reg <= mdy3_reg * dhi_c;
            len4_reg  <= len3_reg;
        end
    end

    // Stage 5: assemble the dividends.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_reg    <= '0;
            numx5_reg <= '0;
            numy5_reg <= '0;
            len5_reg  <= '0;
        end
        else if (en)
        begin
            s5_reg    <= s4_reg;
            numx5_reg <= num_t'(plox4_reg) + (num_t'(phix4_reg) << DOT_LO_W);
            numy5_reg <= num_t'(ploy4_reg) + (num_t'(phiy4_reg) << DOT_LO_W);
            len5_reg  <= len4_reg;
        end
    end

    assign side  = s5_reg;
    assign num_x = numx5_reg;
    assign num_y = numy5_reg;
    assign len   = len5_reg;

endmodule

// ----- src/scr_divider.sv -----
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, with a final
// round-half-up stage. Depends on scr_pkg.
module scr_divider (
    input  logic           clk,
    input  logic           en,
    input  scr_pkg::num_t  num,
    input  scr_pkg::len_t  len,
    output scr_pkg::quot_t quot
);
    import scr_pkg::*;

    num_t  rem_reg [0:DIV_STEPS-1];
    quot_t q_reg   [0:DIV_STEPS-1];
    len_t  len_reg [0:DIV_STEPS-1];
    num_t  rem_w   [0:DIV_STEPS];
    quot_t q_w     [0:DIV_STEPS];
    len_t  len_w   [0:DIV_STEPS];
    quot_t quot_reg;

    assign rem_w[0] = num;
    assign q_w[0]   = '0;
    assign len_w[0] = len;

    // Each stage tries the divisor shifted to its quotient bit.
    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_step
        localparam int SH = DIV_STEPS - 1 - k;
        num_t trial;
        logic fits;

        assign trial = num_t'(len_w[k]) << SH;
        assign fits  = trial <= rem_w[k];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= fits ? rem_w[k] - trial : rem_w[k];
                q_reg[k]   <= fits ? (q_w[k] | (quot_t'(1) << SH)) : q_w[k];
                len_reg[k] <= len_w[k];
            end
        end

        assign rem_w[k+1] = rem_reg[k];
        assign q_w[k+1]   = q_reg[k];
        assign len_w[k+1] = len_reg[k];
    end

    // Round to nearest, halves up in magnitude.
    logic round_up;
    assign round_up = {rem_w[DIV_STEPS][LEN_W-1:0], 1'b0} >= {1'b0, len_w[DIV_STEPS]};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quot_reg <= q_w[DIV_STEPS] + quot_t'(round_up);
        end
    end

    assign quot = quot_reg;

endmodule

// ----- src/scr_back.sv -----
`timescale 1ns / 1ps
// Back stages: displacement, squared distance, contact test and result fields.
// Depends on scr_pkg.
module scr_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  scr_pkg::side_t  side,
    input  scr_pkg::quot_t  quot_x,
    input  scr_pkg::quot_t  quot_y,
    input  scr_pkg::thr_t   contact_dist_sq,
    output logic            res_valid,
    output scr_pkg::res_t   res
);
    import scr_pkg::*;

    logic   v0_reg, v1_reg, v2_reg;
    err_t   ex0_reg, ey0_reg, ex1_reg, ey1_reg;
    coord_t px0_reg, py0_reg, vx0_reg, vy0_reg;
    coord_t px1_reg, py1_reg, vx1_reg, vy1_reg;
    logic [SQ_W-1:0] sqx1_reg, sqy1_reg;
    res_t   res2_reg;

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= side.valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    // Stage 0: displacement from the projected point or the chosen end.
    err_t rx_c, ry_c, qx_c, qy_c;
    assign rx_c = {side.rx[DIFF_W-1], side.rx};
    assign ry_c = {side.ry[DIFF_W-1], side.ry};
    assign qx_c = err_t'(quot_x);
    assign qy_c = err_t'(quot_y);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ex0_reg <= !side.proj ? side.ex_alt : (side.sgn_x ? rx_c + qx_c : rx_c - qx_c);
            ey0_reg <= !side.proj ? side.ey_alt : (side.sgn_y ? ry_c + qy_c : ry_c - qy_c);
            px0_reg <= side.px;
            py0_reg <= side.py;
            vx0_reg <= side.vx;
            vy0_reg <= side.vy;
        end
    end

    // Stage 1: squares of the displacement.
    logic [SQ_MAG_W-1:0] mex_c, mey_c;
    assign mex_c = abs_err(ex0_reg);
    assign mey_c = abs_err(ey0_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx1_reg <= mex_c * mex_c;
            sqy1_reg <= mey_c * mey_c;
            ex1_reg  <= ex0_reg;
            ey1_reg  <= ey0_reg;
            px1_reg  <= px0_reg;
            py1_reg  <= py0_reg;
            vx1_reg  <= vx0_reg;
            vy1_reg  <= vy0_reg;
        end
    end

    // Stage 2: contact test and result selection.
    logic [DSQ_W-1:0]  dsq_c, thr_c;
    logic [WIDE_W-1:0] ex_w, ey_w, npx_w, npy_w;
    logic              contact_c;
    assign dsq_c     = DSQ_W'(sqx1_reg) + DSQ_W'(sqy1_reg);
    assign thr_c     = DSQ_W'(contact_dist_sq) << FRAC_W;
    assign contact_c = dsq_c < thr_c;
    assign ex_w      = {ex1_reg[ERR_W-1], ex1_reg};
    assign ey_w      = {ey1_reg[ERR_W-1], ey1_reg};
    assign npx_w     = {{(WIDE_W-COORD_W){px1_reg[COORD_W-1]}}, px1_reg} - ex_w;
    assign npy_w     = {{(WIDE_W-COORD_W){py1_reg[COORD_W-1]}}, py1_reg} - ey_w;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res2_reg.disp_x    <= sat_wide(ex_w);
            res2_reg.disp_y    <= sat_wide(ey_w);
            res2_reg.contact   <= contact_c;
            res2_reg.new_pos_x <= contact_c ? sat_wide(npx_w) : px1_reg;
            res2_reg.new_pos_y <= contact_c ? sat_wide(npy_w) : py1_reg;
            res2_reg.new_vel_x <= contact_c ? '0 : vx1_reg;
            res2_reg.new_vel_y <= contact_c ? '0 : vy1_reg;
        end
    end

    assign res_valid = v2_reg;
    assign res       = res2_reg;

endmodule

// ----- src/segment_contact_resolver.sv -----
`timescale 1ns / 1ps
// Top level of the segment contact resolver: configuration registers, pipeline
// and output buffering. Depends on scr_pkg, scr_front, scr_divider and scr_back.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one particle: position and
//   velocity. Output channel (out_valid / out_stall) returns one result per
//   particle in order: displacement from the nearest segment point, contact
//   flag, snapped position and velocity.
//   The segment end points and the contact threshold are written through
//   cfg_we / cfg_index / cfg_data while no particle is in flight.
//   Throughput is one particle per cycle while in_stall is low. An item passes
//   44 registers: 6 front stages, a 33-stage divider plus one rounding stage,
//   3 back stages and the output register; the first is loaded at the input
//   transfer edge.
//   Reset clears all valid bits and loads the registers with a zero-length
//   segment at the origin and a threshold of one half; no clearing pass.
//   When the receiver stalls, a finished result waits in the output register
//   and the next one in a skid register; only when the skid register is
//   occupied is in_stall raised and the whole pipeline held.
module segment_contact_resolver (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  scr_pkg::coord_t               pos_x,
    input  scr_pkg::coord_t               pos_y,
    input  scr_pkg::coord_t               vel_x,
    input  scr_pkg::coord_t               vel_y,
    output logic                          out_valid,
    input  logic                          out_stall,
    output scr_pkg::coord_t               disp_x,
    output scr_pkg::coord_t               disp_y,
    output logic                          contact,
    output scr_pkg::coord_t               new_pos_x,
    output scr_pkg::coord_t               new_pos_y,
    output scr_pkg::coord_t               new_vel_x,
    output scr_pkg::coord_t               new_vel_y,
    input  logic                          cfg_we,
    input  logic [scr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [scr_pkg::THR_W-1:0]     cfg_data
);
    import scr_pkg::*;

    coord_t start_x_reg, start_y_reg, end_x_reg, end_y_reg;
    thr_t   dist_sq_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg <= '0;
            start_y_reg <= '0;
            end_x_reg   <= '0;
            end_y_reg   <= '0;
            dist_sq_reg <= DIST_SQ_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_START_X: start_x_reg <= cfg_data[COORD_W-1:0];
                CFG_START_Y: start_y_reg <= cfg_data[COORD_W-1:0];
                CFG_END_X:   end_x_reg   <= cfg_data[COORD_W-1:0];
                CFG_END_Y:   end_y_reg   <= cfg_data[COORD_W-1:0];
                CFG_DIST_SQ: dist_sq_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // The pipeline advances unless the skid register holds a result.
    logic skid_valid_reg, out_valid_reg;
    res_t skid_reg, out_reg;
    logic en;
    assign en       = !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    side_t front_side;
    num_t  num_x, num_y;
    len_t  len;

    scr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (in_valid),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .vel_x       (vel_x),
        .vel_y       (vel_y),
        .seg_start_x (start_x_reg),
        .seg_start_y (start_y_reg),
        .seg_end_x   (end_x_reg),
        .seg_end_y   (end_y_reg),
        .side        (front_side),
        .num_x       (num_x),
        .num_y       (num_y),
        .len         (len)
    );

    quot_t quot_x, quot_y;

    scr_divider u_div_x (
        .clk  (clk),
        .en   (en),
        .num  (num_x),
        .len  (len),
        .quot (quot_x)
    );

    scr_divider u_div_y (
        .clk  (clk),
        .en   (en),
        .num  (num_y),
        .len  (len),
        .quot (quot_y)
    );

    // Item data delayed alongside the dividers.
    side_t dly_reg [0:DIV_LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_LAT; i++)
            begin
                dly_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            dly_reg[0] <= front_side;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                dly_reg[i] <= dly_reg[i-1];
            end
        end
    end

    logic res_valid;
    res_t res;

    scr_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (en),
        .side            (dly_reg[DIV_LAT-1]),
        .quot_x          (quot_x),
        .quot_y          (quot_y),
        .contact_dist_sq (dist_sq_reg),
        .res_valid       (res_valid),
        .res             (res)
    );

    // Output register with skid register.
    logic out_take, arrive;
    assign out_take = out_valid_reg && !out_stall;
    assign arrive   = en && res_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (arrive)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (arrive)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_reg <= res;
            end
            else
            begin
                out_reg <= res;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign disp_x    = out_reg.disp_x;
    assign disp_y    = out_reg.disp_y;
    assign contact   = out_reg.contact;
    assign new_pos_x = out_reg.new_pos_x;
    assign new_pos_y = out_reg.new_pos_y;
    assign new_vel_x = out_reg.new_vel_x;
    assign new_vel_y = out_reg.new_vel_y;

endmodule
